// ===== src/grid_rectangle_first_fit_placer_top_assert.svh =====
// Assertion macros for the grid rectangle placer.
`ifndef GRID_RECTANGLE_FIRST_FIT_PLACER_TOP_ASSERT_SVH
`define GRID_RECTANGLE_FIRST_FIT_PLACER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define GRFFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define GRFFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/grffp_pkg.sv =====
// Package: widths, register indexes, command codes and defaults of the placer.
package grffp_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 16;
  localparam int unsigned MAX_ROWS_DEF    = 16;
  localparam int unsigned ID_BITS_DEF     = 8;

  // field widths
  localparam int unsigned ITEM_ID_W  = 8;
  localparam int unsigned EXTENT_W   = 5;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned POS_W      = 4;

  // beat layouts, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  // position + extent sums stay below 64 + 31, so 8 bits always suffice
  localparam int unsigned SUM_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [CFG_DATA_W-1:0] GRID_COLUMNS_RST = 5'd16;
  localparam logic [CFG_DATA_W-1:0] GRID_ROWS_RST    = 5'd16;

endpackage

// ===== src/grid_rectangle_first_fit_placer_top.sv =====
// Top level: first-fit rectangle placer over a grid of cell owner IDs.
//
//  channel  | direction | beat contents
//  ---------+-----------+-------------------------------------------------------
//  in_*     | sink      | tuser: command; tdata: item_id, item_width, item_height
//  out_*    | source    | tdata: placed, place_column, place_row, was_rotated
//  cfg_*    | sink      | cfg_index 0 grid_columns, 1 grid_rows; no read-back
//
//  Add: each pass walks top-left positions in row-major order; a position whose
//  rectangle leaves the grid is dropped at once (a whole row or the rest of the pass
//  is skipped), otherwise its covered rows go one at a time through the shared
//  row-mask compare until a row collides. If the first pass finds no spot, a second
//  pass runs with the extents swapped; a fit is then filled (one cell write a cycle)
//  and reported. Remove: a sweep over every cell, one owner-memory read a cycle.
//  Reset clears the occupancy flops at once, so no clearing pass is needed.
//  in_tready is high only when idle; a finished result waits in the output
//  register while the next beat is taken.
module grid_rectangle_first_fit_placer_top #(
  parameter int unsigned MAX_COLUMNS = grffp_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = grffp_pkg::MAX_ROWS_DEF,
  parameter int unsigned ID_BITS     = grffp_pkg::ID_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // write port for grid_columns / grid_rows
  input  logic                                  cfg_we,
  input  logic [grffp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [grffp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // command stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [7:0] item_id, [12:8] item_width, [17:13] item_height, [23:18] zero
  input  logic [grffp_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] command
  input  logic                                  in_tuser,
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] placed, [4:1] place_column, [8:5] place_row, [9] was_rotated, [15:10] zero
  output logic [grffp_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import grffp_pkg::*;

  localparam int unsigned CB = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_FILL    = 3'd2;
  localparam logic [2:0] ST_RM      = 3'd3;
  localparam logic [2:0] ST_RM_TAIL = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [CFG_DATA_W-1:0] grid_columns_r, grid_rows_r;
  logic [SUM_W-1:0]      cols_u, rows_u;

  // latched command
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [EXTENT_W-1:0] w_r, w_nxt, h_r, h_nxt;

  // scan position and result
  logic [CB-1:0]       x_r, x_nxt;
  logic [RB-1:0]       y_r, y_nxt;
  logic [EXTENT_W-1:0] k_r, k_nxt;
  logic                rot_r, rot_nxt;
  logic                ok_r, ok_nxt;

  // fill walk
  logic [EXTENT_W-1:0] fx_r, fx_nxt, fy_r, fy_nxt;

  // remove sweep
  logic [CB-1:0] rm_col_r, rm_col_nxt, p_col_r;
  logic [RB-1:0] rm_row_r, rm_row_nxt, p_row_r;
  logic          p_v_r, p_v_nxt;

  // storage: occupancy flops act as valid bits for the owner memory
  logic [MAX_ROWS-1:0][MAX_COLUMNS-1:0] occ_r;
  logic [ID_BITS-1:0] mem_r [MAX_ROWS][MAX_COLUMNS];
  logic [ID_BITS-1:0] rd_data_r;

  logic                out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // datapath helpers
  logic                in_fire;
  logic [ID_BITS-1:0]  in_id;
  logic [EXTENT_W-1:0] in_w, in_h, ew, eh;
  logic [SUM_W-1:0]    x_end, y_end;
  logic [RB-1:0]       chk_row, fill_row;
  logic [CB-1:0]       fill_col;
  logic [MAX_COLUMNS-1:0] span_mask, row_bits;
  logic                fill_we, clr_we;

  assign in_fire = in_tvalid && in_tready;
  assign in_id   = ID_BITS'(in_tdata[7:0]);
  assign in_w    = in_tdata[12:8];
  assign in_h    = in_tdata[17:13];

  // saturate registers to the grid's physical size
  assign cols_u = (SUM_W'(grid_columns_r) > SUM_W'(MAX_COLUMNS)) ?
                  SUM_W'(MAX_COLUMNS) : SUM_W'(grid_columns_r);
  assign rows_u = (SUM_W'(grid_rows_r) > SUM_W'(MAX_ROWS)) ?
                  SUM_W'(MAX_ROWS) : SUM_W'(grid_rows_r);

  assign ew = rot_r ? h_r : w_r;
  assign eh = rot_r ? w_r : h_r;

  assign x_end = SUM_W'(x_r) + SUM_W'(ew);
  assign y_end = SUM_W'(y_r) + SUM_W'(eh);

  assign chk_row = RB'(SUM_W'(y_r) + SUM_W'(k_r));
  assign row_bits = occ_r[chk_row];

  always_comb begin
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      span_mask[j] = (SUM_W'(j) >= SUM_W'(x_r)) && (SUM_W'(j) < x_end);
    end
  end

  assign fill_row = RB'(SUM_W'(y_r) + SUM_W'(fy_r));
  assign fill_col = CB'(SUM_W'(x_r) + SUM_W'(fx_r));
  assign fill_we  = (state_r == ST_FILL);
  assign clr_we   = p_v_r && occ_r[p_row_r][p_col_r] && (rd_data_r == id_r);

  // result beat; failed adds and removes carry a zero position
  always_comb begin
    out_tdata_nxt    = '0;
    out_tdata_nxt[0] = ok_r;
    if (ok_r) begin
      out_tdata_nxt[4:1] = POS_W'(x_r);
      out_tdata_nxt[8:5] = POS_W'(y_r);
      out_tdata_nxt[9]   = rot_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    id_nxt     = id_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    k_nxt      = k_r;
    rot_nxt    = rot_r;
    ok_nxt     = ok_r;
    fx_nxt     = fx_r;
    fy_nxt     = fy_r;
    rm_col_nxt = rm_col_r;
    rm_row_nxt = rm_row_r;
    p_v_nxt    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          id_nxt     = in_id;
          w_nxt      = in_w;
          h_nxt      = in_h;
          x_nxt      = '0;
          y_nxt      = '0;
          k_nxt      = '0;
          rot_nxt    = 1'b0;
          fx_nxt     = '0;
          fy_nxt     = '0;
          rm_col_nxt = '0;
          rm_row_nxt = '0;
          if (in_tuser == CMD_REMOVE) begin
            ok_nxt    = 1'b1;
            state_nxt = (in_id == '0) ? ST_DONE : ST_RM;
          end else begin
            ok_nxt = 1'b0;
            if (in_id == '0 || in_w == '0 || in_h == '0 || cols_u == '0 || rows_u == '0) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (y_end > rows_u || (x_end > cols_u && SUM_W'(y_r) + 1'b1 == rows_u) ||
            ((|(row_bits & span_mask)) && SUM_W'(x_r) + 1'b1 == cols_u &&
             SUM_W'(y_r) + 1'b1 == rows_u)) begin
          // pass exhausted
          x_nxt = '0;
          y_nxt = '0;
          k_nxt = '0;
          if (!rot_r) begin
            rot_nxt = 1'b1;
          end else begin
            rot_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end
        end else if (x_end > cols_u ||
                     ((|(row_bits & span_mask)) && SUM_W'(x_r) + 1'b1 == cols_u)) begin
          // next row of positions
          x_nxt = '0;
          y_nxt = y_r + 1'b1;
          k_nxt = '0;
        end else if (|(row_bits & span_mask)) begin
          x_nxt = x_r + 1'b1;
          k_nxt = '0;
        end else if (k_r == eh - 1'b1) begin
          fx_nxt    = '0;
          fy_nxt    = '0;
          state_nxt = ST_FILL;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      ST_FILL: begin
        if (fx_r == ew - 1'b1) begin
          fx_nxt = '0;
          if (fy_r == eh - 1'b1) begin
            ok_nxt    = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            fy_nxt = fy_r + 1'b1;
          end
        end else begin
          fx_nxt = fx_r + 1'b1;
        end
      end

      ST_RM: begin
        p_v_nxt = 1'b1;
        if (rm_col_r == CB'(MAX_COLUMNS - 1)) begin
          rm_col_nxt = '0;
          if (rm_row_r == RB'(MAX_ROWS - 1)) begin
            state_nxt = ST_RM_TAIL;
          end else begin
            rm_row_nxt = rm_row_r + 1'b1;
          end
        end else begin
          rm_col_nxt = rm_col_r + 1'b1;
        end
      end

      ST_RM_TAIL: begin
        // last compare lands this cycle
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      grid_columns_r <= GRID_COLUMNS_RST;
      grid_rows_r    <= GRID_ROWS_RST;
      p_v_r          <= 1'b0;
      out_tvalid_r   <= 1'b0;
      occ_r          <= '0;
    end else begin
      state_r <= state_nxt;
      p_v_r   <= p_v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_COLUMNS: grid_columns_r <= cfg_wdata;
          REG_GRID_ROWS:    grid_rows_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (fill_we) begin
        occ_r[fill_row][fill_col] <= 1'b1;
      end
      if (clr_we) begin
        occ_r[p_row_r][p_col_r] <= 1'b0;
      end
      if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    k_r      <= k_nxt;
    rot_r    <= rot_nxt;
    ok_r     <= ok_nxt;
    fx_r     <= fx_nxt;
    fy_r     <= fy_nxt;
    rm_col_r <= rm_col_nxt;
    rm_row_r <= rm_row_nxt;
    p_col_r  <= rm_col_r;
    p_row_r  <= rm_row_r;
    if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  // owner memory: one write, one registered read a cycle
  always_ff @(posedge clk) begin
    if (fill_we) begin
      mem_r[fill_row][fill_col] <= id_r;
    end
    rd_data_r <= mem_r[rm_row_r][rm_col_r];
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`include "grid_rectangle_first_fit_placer_top_assert.svh"

  `GRFFP_ASSERT_NOW(a_fail_zero_pos, out_tvalid_r && !out_tdata_r[0],
                    out_tdata_r[9:1] == '0, "failed add reports a non-zero position")
  `GRFFP_ASSERT_NOW(a_fill_in_grid, state_r == ST_FILL,
                    SUM_W'(fill_row) < rows_u && SUM_W'(fill_col) < cols_u,
                    "fill outside the grid in use")
  `GRFFP_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != ST_IDLE,
                     "accepted beat did not start work")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the first-fit grid rectangle placer: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import grffp_pkg::*;

  // Grid geometry of the default build; cell (x,y) lives at y*GRID_W + x whatever the registers say.
  localparam int GRID_W = MAX_COLUMNS_DEF;
  localparam int GRID_H = MAX_ROWS_DEF;
  // Slowest legal item: two full scans over every position and row, a full fill, plus the
  // worst stall and gap. About 165 items of that, then taken four times over.
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int RANDOM_PER_PHASE = 20;
  localparam int NUM_PHASES = 7;

  // One result beat, laid out as in out_tdata, members listed from the highest bit down.
  typedef struct packed {
    logic       rotated;
    logic [3:0] row;
    logic [3:0] col;
    logic       placed;
  } placement_t;

  // One row of the directed stimulus; pinned rows carry a hand-typed result.
  typedef struct packed {
    logic       cmd;
    logic [7:0] id;
    logic [4:0] w;
    logic [4:0] h;
    logic       pinned;
    placement_t res;
  } stim_row_t;

  localparam placement_t NOT_PLACED = '{1'b0, 4'd0, 4'd0, 1'b0};
  localparam placement_t AT_ORIGIN  = '{1'b0, 4'd0, 4'd0, 1'b1};

  // Directed part, run on the reset grid of 16 x 16.
  localparam stim_row_t DIRECTED_ROWS [20] = '{
    '{CMD_ADD,    8'd1,   5'd16, 5'd16, 1'b1, AT_ORIGIN},   // whole grid in one item
    '{CMD_ADD,    8'd2,   5'd1,  5'd1,  1'b1, NOT_PLACED},  // grid full
    '{CMD_REMOVE, 8'd2,   5'd0,  5'd0,  1'b1, AT_ORIGIN},   // ID not present
    '{CMD_REMOVE, 8'd1,   5'd0,  5'd0,  1'b1, AT_ORIGIN},
    '{CMD_ADD,    8'd0,   5'd3,  5'd3,  1'b1, NOT_PLACED},  // ID zero refused
    '{CMD_ADD,    8'd5,   5'd0,  5'd4,  1'b1, NOT_PLACED},  // zero width
    '{CMD_ADD,    8'd6,   5'd4,  5'd0,  1'b1, NOT_PLACED},  // zero height
    '{CMD_ADD,    8'd7,   5'd17, 5'd1,  1'b1, NOT_PLACED},  // too wide either way round
    '{CMD_ADD,    8'd255, 5'd31, 5'd31, 1'b1, NOT_PLACED},  // largest extents
    '{CMD_REMOVE, 8'd0,   5'd31, 5'd31, 1'b1, AT_ORIGIN},   // remove of ID zero is a no-op
    '{CMD_ADD,    8'hAA,  5'd16, 5'd2,  1'b1, AT_ORIGIN},   // top two rows
    '{CMD_ADD,    8'h55,  5'd3,  5'd15, 1'b0, NOT_PLACED},  // only fits turned
    '{CMD_ADD,    8'h55,  5'd1,  5'd1,  1'b0, NOT_PLACED},  // same ID placed twice
    '{CMD_REMOVE, 8'h55,  5'd0,  5'd0,  1'b0, NOT_PLACED},  // clears both copies
    '{CMD_ADD,    8'hFF,  5'd16, 5'd14, 1'b0, NOT_PLACED},  // fills the rest
    '{CMD_ADD,    8'h80,  5'd2,  5'd2,  1'b0, NOT_PLACED},
    '{CMD_REMOVE, 8'hAA,  5'd0,  5'd0,  1'b0, NOT_PLACED},
    '{CMD_ADD,    8'h7E,  5'd2,  5'd3,  1'b0, NOT_PLACED},  // turned into the freed rows
    '{CMD_REMOVE, 8'hFF,  5'd0,  5'd0,  1'b0, NOT_PLACED},
    '{CMD_REMOVE, 8'h7E,  5'd0,  5'd0,  1'b0, NOT_PLACED}
  };

  // Register settings per random phase; 0, 17 and 31 cover the empty and saturating cases.
  localparam int PHASE_COLS [NUM_PHASES] = '{4, 0, 31, 1, 7, 17, 16};
  localparam int PHASE_ROWS [NUM_PHASES] = '{4, 7, 3, 1, 31, 0, 16};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // [7:0] item_id, [12:8] item_width, [17:13] item_height
  logic                  in_tuser;    // [0] command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // [0] placed, [4:1] column, [8:5] row, [9] was_rotated

  // Predictor state: our own copy of the owner grid and of both registers.
  logic [7:0]            owner_map [GRID_W*GRID_H];
  logic [CFG_DATA_W-1:0] grid_cols_cfg;
  logic [CFG_DATA_W-1:0] grid_rows_cfg;

  placement_t placements_due [$];   // predicted results, oldest first
  logic [7:0] live_ids [$];         // IDs believed to be on the grid, steers removes
  int         fail_count;
  int         cycle_count;
  bit         idle_on;              // random gaps and stalls enabled
  int         ready_wait;

  grid_rectangle_first_fit_placer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // First free spot for a w x h rectangle, rows top to bottom, columns left to right.
  function automatic bit first_fit(input int w, input int h, output int fx, output int fy);
    int  cols;
    int  rows;
    bit  clear;
    cols = (grid_cols_cfg > GRID_W) ? GRID_W : int'(grid_cols_cfg);
    rows = (grid_rows_cfg > GRID_H) ? GRID_H : int'(grid_rows_cfg);
    fx = 0;
    fy = 0;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        if (x + w <= cols && y + h <= rows) begin
          clear = 1'b1;
          for (int yy = y; yy < y + h; yy++)
            for (int xx = x; xx < x + w; xx++)
              if (owner_map[yy*GRID_W + xx] != 8'd0) clear = 1'b0;
          if (clear) begin
            fx = x;
            fy = y;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Applies one command to the owner grid and returns the beat it should produce.
  function automatic placement_t predict_placement(logic cmd, logic [7:0] id,
                                                   logic [4:0] w, logic [4:0] h);
    placement_t res;
    int         fx;
    int         fy;
    int         ew;
    int         eh;
    bit         hit;
    res = NOT_PLACED;
    if (cmd == CMD_REMOVE) begin
      if (id != 8'd0)
        for (int i = 0; i < GRID_W*GRID_H; i++)
          if (owner_map[i] == id) owner_map[i] = 8'd0;
      res.placed = 1'b1;
    end else if (id != 8'd0 && w != 5'd0 && h != 5'd0) begin
      ew = w;
      eh = h;
      hit = first_fit(ew, eh, fx, fy);
      if (!hit) begin
        // second pass with the extents swapped
        ew = h;
        eh = w;
        hit = first_fit(ew, eh, fx, fy);
        res.rotated = hit;
      end
      if (hit) begin
        for (int y = fy; y < fy + eh; y++)
          for (int x = fx; x < fx + ew; x++)
            owner_map[y*GRID_W + x] = id;
        res.placed = 1'b1;
        res.col    = fx[3:0];
        res.row    = fy[3:0];
      end
    end
    return res;
  endfunction

  // Mostly small extents so that scans stay short; now and then up to a full side.
  function automatic logic [4:0] pick_extent(int lim);
    int eff;
    eff = (lim > 16) ? 16 : lim;
    if (eff < 1) eff = 4;
    if ($urandom_range(0, 4) == 0) return 5'($urandom_range(1, 16));
    return 5'($urandom_range(1, (eff < 4) ? eff : 4));
  endfunction

  // Presents one command beat, waits for the handshake, then records the expectation.
  // tvalid stays high after the beat so back-to-back items never toggle it in one step.
  task automatic send_item(logic cmd, logic [7:0] id, logic [4:0] w, logic [4:0] h,
                           logic pinned, placement_t pinned_res);
    int         gap;
    placement_t due;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, h, w, id};
    do @(posedge clk); while (!in_tready);
    due = predict_placement(cmd, id, w, h);
    if (pinned) due = pinned_res;
    placements_due.push_back(due);
    // keep the live list roughly in step so removes mostly hit something
    if (cmd == CMD_REMOVE) begin
      for (int i = live_ids.size() - 1; i >= 0; i--)
        if (live_ids[i] == id) live_ids.delete(i);
    end else if (due.placed) begin
      live_ids.push_back(id);
    end
  endtask

  // Drop tvalid on the step of the last handshake, then wait until every beat is back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
  endtask

  // Writes both registers in consecutive cycles, columns then rows; the mirror follows each write edge.
  task automatic set_grid(logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    grid_cols_cfg = cols;
    cfg_index <= REG_GRID_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    grid_rows_cfg = rows;
    cfg_we <= 1'b0;
  endtask

  // Compares one result beat with the oldest expectation.
  task automatic check_beat(logic [OUT_DATA_W-1:0] beat);
    placement_t seen;
    placement_t want;
    seen = beat[9:0];
    if (placements_due.size() == 0) begin
      $error("result beat %h arrived with nothing expected", beat);
      fail_count++;
    end else begin
      want = placements_due.pop_front();
      if (seen.placed !== want.placed) begin
        $error("placed: expected %0d, got %0d", want.placed, seen.placed);
        fail_count++;
      end
      if (seen.col !== want.col) begin
        $error("place_column: expected %0d, got %0d", want.col, seen.col);
        fail_count++;
      end
      if (seen.row !== want.row) begin
        $error("place_row: expected %0d, got %0d", want.row, seen.row);
        fail_count++;
      end
      if (seen.rotated !== want.rotated) begin
        $error("was_rotated: expected %0d, got %0d", want.rotated, seen.rotated);
        fail_count++;
      end
    end
  endtask

  // Result side: values are read before this edge's updates land, and tready is
  // held low for a freshly drawn number of cycles after every accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_beat(out_tdata);
        ready_wait = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (ready_wait > 0) begin
        out_tready <= 1'b0;
        ready_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int         r;
    logic       cmd;
    logic [7:0] id;
    logic [4:0] w;
    logic [4:0] h;

    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_ADD;
    fail_count = 0;
    idle_on    = 1'b1;
    foreach (owner_map[i]) owner_map[i] = 8'd0;
    grid_cols_cfg = GRID_COLUMNS_RST;
    grid_rows_cfg = GRID_ROWS_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows on the reset 16 x 16 grid.
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].id, DIRECTED_ROWS[i].w,
                DIRECTED_ROWS[i].h, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].res);
    drain_results();

    // Random phases. The grid is never cleared between them, so cells left
    // outside a shrunken area stay owned and later removes must still find them.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_grid(5'(PHASE_COLS[p]), 5'(PHASE_ROWS[p]));
      idle_on = (p % 3 != 2);   // every third phase runs flat out
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        w = 5'd0;
        h = 5'd0;
        if (r < 55) begin
          // well-formed add, now and then reusing a live ID
          cmd = CMD_ADD;
          if (live_ids.size() != 0 && $urandom_range(0, 9) == 0)
            id = live_ids[$urandom_range(0, live_ids.size() - 1)];
          else
            id = 8'($urandom_range(1, 255));
          w = pick_extent(grid_cols_cfg);
          h = pick_extent(grid_rows_cfg);
        end else if (r < 85) begin
          cmd = CMD_REMOVE;
          if (live_ids.size() != 0)
            id = live_ids[$urandom_range(0, live_ids.size() - 1)];
          else
            id = 8'($urandom_range(1, 255));
        end else begin
          // noise: any command, any ID (zero likely), any extent up to 31
          cmd = $urandom_range(0, 1) ? CMD_REMOVE : CMD_ADD;
          id  = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
          w   = 5'($urandom_range(0, 31));
          h   = 5'($urandom_range(0, 31));
        end
        send_item(cmd, id, w, h, 1'b0, NOT_PLACED);
        // mid-phase hold-off: let the block run completely dry once
        if (p == 1 && k == RANDOM_PER_PHASE / 2) drain_results();
      end
      drain_results();
    end

    // Everything is back; leave room for any stray beat to show up.
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
